/* rtl/core/stc_pkg.sv */
// shared widths, limits, register indexes and mode bits of the speed to current block
`timescale 1ns / 1ps
`default_nettype none

package stc_pkg;

    // field widths
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned TEETH_W    = 16;
    localparam int unsigned SPEED_W    = 24;
    localparam int unsigned CODE_W     = 16;
    localparam int unsigned MODE_W     = 5;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 24;

    // frequency window and speed scaling
    localparam int unsigned FREQ_LOW_LIMIT     = 60;
    localparam int unsigned FREQ_HIGH_LIMIT    = 20000;
    localparam int unsigned SECONDS_PER_MINUTE = 60;
    localparam int unsigned WINDOW_FACTOR      = 2;

    localparam int unsigned COUNT_MAX = (2 ** COUNT_W) - 1;
    localparam int unsigned FREQ_W    = $clog2(COUNT_MAX * WINDOW_FACTOR + 1);
    localparam int unsigned NUM_W     =
        $clog2(COUNT_MAX * WINDOW_FACTOR * SECONDS_PER_MINUTE + 1);

    // shared divider: dividend wide enough for the speed numerator and the code scale
    localparam int unsigned DIV_W  = (NUM_W > CODE_W) ? NUM_W : CODE_W;
    localparam int unsigned CNT_W  = $clog2(DIV_W + 1);
    localparam int unsigned PROD_W = SPEED_W + CODE_W;

    localparam int unsigned SPEED_MAX = (2 ** SPEED_W) - 1;
    localparam int unsigned CODE_MAX  = (2 ** CODE_W) - 1;

    // reset values of the setup registers
    localparam int unsigned TEETH_RESET     = 1;
    localparam int unsigned MAX_SPEED_RESET = 1000;

    // setup register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TEETH     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_R1_ON     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_R1_OFF    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_R2_ON     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_R2_OFF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_SPEED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_MODE      = 3'd7;

    // mode bit positions
    localparam int unsigned MODE_R1_EN    = 0;
    localparam int unsigned MODE_R1_LATCH = 1;
    localparam int unsigned MODE_R2_EN    = 2;
    localparam int unsigned MODE_R2_LATCH = 3;
    localparam int unsigned MODE_VOLTAGE  = 4;

endpackage

`default_nettype wire

/* rtl/core/stc_div.sv */
// shared restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none

module stc_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [stc_pkg::DIV_W-1:0]   i_dividend,
    input  wire logic [stc_pkg::SPEED_W-1:0] i_divisor,
    output logic [stc_pkg::DIV_W-1:0]        o_quot,
    output logic                             o_done
);
    import stc_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [DIV_W-1:0]    r_dvd;
    logic [SPEED_W-1:0]  r_rem;
    logic [SPEED_W-1:0]  r_dvs;

    logic [SPEED_W:0]    w_trial;
    logic                w_ge;
    logic [SPEED_W-1:0]  n_rem;
    logic [DIV_W-1:0]    n_dvd;

    // trial subtract of the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_dvd[DIV_W-1]};
        w_ge    = (w_trial >= {1'b0, r_dvs});
        if (w_ge) begin
            n_rem = SPEED_W'(w_trial - {1'b0, r_dvs});
        end else begin
            n_rem = w_trial[SPEED_W-1:0];
        end
        n_dvd = {r_dvd[DIV_W-2:0], w_ge};
    end

    // control: step counter, busy and done
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DIV_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: dividend shifts out, quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_dvd <= n_dvd;
            r_rem <= n_rem;
        end
    end

    assign o_quot = r_dvd;
    assign o_done = r_done;

    // checks
    a_start_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy)
        else $error("divider did not start");
    a_done_idle : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy)
        else $error("divider done while busy");
    // a zero divisor leaves the remainder unbounded, its result is not used
    a_rem_below : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy && (r_dvs != '0)) |-> (r_rem < r_dvs))
        else $error("divider remainder out of range");

endmodule

`default_nettype wire

/* rtl/core/stc_relay.sv */
// one speed relay with enable, auto reset and latch behavior
`timescale 1ns / 1ps
`default_nettype none

module stc_relay (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_update,
    input  wire logic                        i_enable,
    input  wire logic                        i_latch,
    input  wire logic [stc_pkg::SPEED_W-1:0] i_speed,
    input  wire logic [stc_pkg::SPEED_W-1:0] i_on_speed,
    input  wire logic [stc_pkg::SPEED_W-1:0] i_off_speed,
    output logic                             o_closed
);
    import stc_pkg::*;

    logic r_closed;
    logic n_closed;

    // close at or above on, open at or below off unless latched
    always_comb begin
        n_closed = r_closed;
        if (i_update && i_enable) begin
            if (i_speed >= i_on_speed) begin
                n_closed = 1'b1;
            end
            if (!i_latch && (i_speed <= i_off_speed)) begin
                n_closed = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_closed <= 1'b0;
        end else begin
            r_closed <= n_closed;
        end
    end

    assign o_closed = r_closed;

endmodule

`default_nettype wire

/* rtl/core/speed_to_current_with_relay_trips.sv */
// speed to current converter top: setup registers, sequencer, multiplier, output register
// flow: two divisions on the shared divider (speed, then the code scale), then a
//   multiply state and a clamp state before o_valid
// no new word until the last result is accepted; o_ready is high only while idle
// reset: synchronous active low; relays open, teeth_count 1, max_speed 1000, other setup 0
// setup writes are taken on every cycle (o_cfg_ready stays high)
`timescale 1ns / 1ps
`default_nettype none

module speed_to_current_with_relay_trips (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    // setup write channel
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic [stc_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [stc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    // input channel
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic [stc_pkg::COUNT_W-1:0]    i_pulse_count,
    // output channel
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [stc_pkg::SPEED_W-1:0]         o_speed,
    output logic                                o_relay1_closed,
    output logic                                o_relay2_closed,
    output logic [stc_pkg::CODE_W-1:0]          o_current_code,
    output logic                                o_current_valid
);
    import stc_pkg::*;

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SPD_GO = 3'd1;
    localparam logic [2:0] S_SPD    = 3'd2;
    localparam logic [2:0] S_SCL_GO = 3'd3;
    localparam logic [2:0] S_SCL    = 3'd4;
    localparam logic [2:0] S_MUL    = 3'd5;
    localparam logic [2:0] S_CLAMP  = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    // setup registers
    logic [TEETH_W-1:0] r_teeth;
    logic [SPEED_W-1:0] r_r1_on;
    logic [SPEED_W-1:0] r_r1_off;
    logic [SPEED_W-1:0] r_r2_on;
    logic [SPEED_W-1:0] r_r2_off;
    logic [SPEED_W-1:0] r_min;
    logic [SPEED_W-1:0] r_max;
    logic [MODE_W-1:0]  r_mode;

    // sequencer and datapath registers
    logic [2:0]         r_state;
    logic [2:0]         n_state;
    logic [NUM_W-1:0]   r_num;
    logic [SPEED_W-1:0] r_speed;
    logic [CODE_W-1:0]  r_scale;
    logic [PROD_W-1:0]  r_prod;
    logic               r_code_en;
    logic               r_out_valid;
    logic [SPEED_W-1:0] r_out_speed;
    logic [CODE_W-1:0]  r_out_code;
    logic               r_out_cur;

    logic [FREQ_W-1:0]  w_freq;
    logic               w_freq_ok;
    logic [NUM_W-1:0]   w_num;
    logic               w_in_acc;
    logic               w_out_acc;
    logic               w_div_start;
    logic [DIV_W-1:0]   w_div_dvd;
    logic [SPEED_W-1:0] w_div_dvs;
    logic [DIV_W-1:0]   w_quot;
    logic               w_div_done;
    logic [SPEED_W-1:0] w_span;
    logic [SPEED_W-1:0] w_speed_sat;
    logic               w_relay_upd;
    logic               w_r1_closed;
    logic               w_r2_closed;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = (r_state == S_IDLE);
    assign w_in_acc    = i_valid && o_ready;
    assign w_out_acc   = r_out_valid && i_ready;

    // setup register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_teeth  <= TEETH_W'(TEETH_RESET);
            r_r1_on  <= '0;
            r_r1_off <= '0;
            r_r2_on  <= '0;
            r_r2_off <= '0;
            r_min    <= '0;
            r_max    <= SPEED_W'(MAX_SPEED_RESET);
            r_mode   <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_TEETH:     r_teeth  <= i_cfg_data[TEETH_W-1:0];
                REG_R1_ON:     r_r1_on  <= i_cfg_data[SPEED_W-1:0];
                REG_R1_OFF:    r_r1_off <= i_cfg_data[SPEED_W-1:0];
                REG_R2_ON:     r_r2_on  <= i_cfg_data[SPEED_W-1:0];
                REG_R2_OFF:    r_r2_off <= i_cfg_data[SPEED_W-1:0];
                REG_MIN_SPEED: r_min    <= i_cfg_data[SPEED_W-1:0];
                REG_MAX_SPEED: r_max    <= i_cfg_data[SPEED_W-1:0];
                REG_MODE:      r_mode   <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // frequency window and speed numerator
    always_comb begin
        w_freq    = FREQ_W'(FREQ_W'(i_pulse_count) * FREQ_W'(WINDOW_FACTOR));
        w_freq_ok = (32'(w_freq) > FREQ_LOW_LIMIT) && (32'(w_freq) < FREQ_HIGH_LIMIT);
        if (w_freq_ok) begin
            w_num = NUM_W'(NUM_W'(w_freq) * NUM_W'(SECONDS_PER_MINUTE));
        end else begin
            w_num = '0;
        end
    end

    // divider operands: speed division first, then the code scale
    assign w_span      = r_max - r_min;
    assign w_div_start = (r_state == S_SPD_GO) || (r_state == S_SCL_GO);
    assign w_div_dvd   = (r_state == S_SPD_GO) ? DIV_W'(r_num) : DIV_W'(CODE_MAX);
    assign w_div_dvs   = (r_state == S_SPD_GO) ? SPEED_W'(r_teeth) : w_span;

    stc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_quot     (w_quot),
        .o_done     (w_div_done)
    );

    // speed saturation, zero teeth gives zero
    always_comb begin
        if (r_teeth == '0) begin
            w_speed_sat = '0;
        end else if (33'(w_quot) > 33'(SPEED_MAX)) begin
            w_speed_sat = SPEED_W'(SPEED_MAX);
        end else begin
            w_speed_sat = SPEED_W'(w_quot);
        end
    end

    // relays update once per word, after the speed is known
    assign w_relay_upd = (r_state == S_SCL_GO);

    stc_relay u_relay1 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_relay_upd),
        .i_enable    (r_mode[MODE_R1_EN]),
        .i_latch     (r_mode[MODE_R1_LATCH]),
        .i_speed     (r_speed),
        .i_on_speed  (r_r1_on),
        .i_off_speed (r_r1_off),
        .o_closed    (w_r1_closed)
    );

    stc_relay u_relay2 (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_update    (w_relay_upd),
        .i_enable    (r_mode[MODE_R2_EN]),
        .i_latch     (r_mode[MODE_R2_LATCH]),
        .i_speed     (r_speed),
        .i_on_speed  (r_r2_on),
        .i_off_speed (r_r2_off),
        .o_closed    (w_r2_closed)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (w_in_acc) n_state = S_SPD_GO;
            S_SPD_GO: n_state = S_SPD;
            S_SPD:    if (w_div_done) n_state = S_SCL_GO;
            S_SCL_GO: n_state = S_SCL;
            S_SCL:    if (w_div_done) n_state = S_MUL;
            S_MUL:    n_state = S_CLAMP;
            S_CLAMP:  n_state = S_OUT;
            S_OUT:    if (w_out_acc) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLAMP) begin
                r_out_valid <= 1'b1;
            end else if (w_out_acc) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_num <= w_num;
        end
        if ((r_state == S_SPD) && w_div_done) begin
            r_speed <= w_speed_sat;
        end
        if ((r_state == S_SCL) && w_div_done) begin
            r_scale <= w_quot[CODE_W-1:0];
        end
        if (r_state == S_MUL) begin
            r_prod    <= PROD_W'(r_speed - r_min) * PROD_W'(r_scale);
            r_code_en <= !r_mode[MODE_VOLTAGE] && (r_max > r_min) && (r_speed > r_min);
        end
        if (r_state == S_CLAMP) begin
            r_out_speed <= r_speed;
            r_out_cur   <= !r_mode[MODE_VOLTAGE];
            if (!r_code_en) begin
                r_out_code <= '0;
            end else if (r_prod > PROD_W'(CODE_MAX)) begin
                r_out_code <= CODE_W'(CODE_MAX);
            end else begin
                r_out_code <= r_prod[CODE_W-1:0];
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_speed         = r_out_speed;
    assign o_relay1_closed = w_r1_closed;
    assign o_relay2_closed = w_r2_closed;
    assign o_current_code  = r_out_code;
    assign o_current_valid = r_out_cur;

    // checks
    a_valid_state : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_OUT))
        else $error("result word shown outside output state");
    a_accept_go : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_SPD_GO))
        else $error("accepted word did not start the speed division");
    a_voltage_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_current_valid) |-> (o_current_code == '0))
        else $error("nonzero code in voltage mode");
    a_done_wait : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == S_SPD) || (r_state == S_SCL)))
        else $error("divider finished with no division pending");

endmodule

`default_nettype wire

/* dv/speed_to_current_with_relay_trips_tb.sv */
// self-checking testbench for the speed to current converter with relay trips
`timescale 1ns / 1ps

module speed_to_current_with_relay_trips_tb;
    import stc_pkg::*;

    localparam int unsigned STALL_PCT     = 29;
    localparam int unsigned IDLE_LIMIT    = 4000;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TAIL_CYCLES   = 60;
    localparam int unsigned PHASES        = 15;
    localparam int unsigned WORDS_PER_PHASE = 50;
    localparam int unsigned PRINT_CAP     = 50;
    // upper bound on the speed the frequency window allows with one tooth
    localparam int unsigned TOP_RPM = (FREQ_HIGH_LIMIT - 1) * SECONDS_PER_MINUTE;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               relay1;
        logic               relay2;
        logic [CODE_W-1:0]  code;
        logic               current_on;
    } t_reading;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                  i_valid;
    logic                  o_ready;
    logic [COUNT_W-1:0]    i_pulse_count;
    logic                  o_valid;
    logic                  i_ready;
    logic [SPEED_W-1:0]    o_speed;
    logic                  o_relay1_closed;
    logic                  o_relay2_closed;
    logic [CODE_W-1:0]     o_current_code;
    logic                  o_current_valid;

    speed_to_current_with_relay_trips dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_pulse_count   (i_pulse_count),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_speed         (o_speed),
        .o_relay1_closed (o_relay1_closed),
        .o_relay2_closed (o_relay2_closed),
        .o_current_code  (o_current_code),
        .o_current_valid (o_current_valid)
    );

    // shadow copy of the setup registers and relay states
    logic [TEETH_W-1:0] teeth_q;
    logic [SPEED_W-1:0] r1_on_q, r1_off_q, r2_on_q, r2_off_q, min_q, max_q;
    logic [MODE_W-1:0]  mode_q;
    logic               relay1_q, relay2_q;

    // register values to load at the next setup write
    logic [CFG_DATA_W-1:0] plan [8];

    t_reading    pending_readings [$];
    t_reading    want;
    int unsigned mismatches;
    int unsigned idle_cycles;
    bit          steady;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic logic next_relay(input logic st, input logic [SPEED_W-1:0] rpm,
                                        input logic [SPEED_W-1:0] on_th,
                                        input logic [SPEED_W-1:0] off_th,
                                        input logic en, input logic latch);
        if (!en) begin
            return st;
        end
        if (rpm >= on_th) begin
            st = 1'b1;
        end
        // auto reset: off wins when both thresholds are met
        if (!latch && rpm <= off_th) begin
            st = 1'b0;
        end
        return st;
    endfunction

    // expected result for one pulse count word, advances the relay states
    function automatic t_reading predict_reading(input logic [COUNT_W-1:0] cnt);
        t_reading         r;
        longint unsigned  freq;
        longint unsigned  rpm;
        longint unsigned  scale;
        longint unsigned  code;
        logic             cur;
        freq = longint'(cnt) * WINDOW_FACTOR;
        if (freq <= FREQ_LOW_LIMIT || freq >= FREQ_HIGH_LIMIT) begin
            freq = 0;
        end
        rpm = 0;
        if (teeth_q != 0) begin
            rpm = (freq * SECONDS_PER_MINUTE) / teeth_q;
        end
        if (rpm > SPEED_MAX) begin
            rpm = SPEED_MAX;
        end
        relay1_q = next_relay(relay1_q, rpm[SPEED_W-1:0], r1_on_q, r1_off_q,
                              mode_q[MODE_R1_EN], mode_q[MODE_R1_LATCH]);
        relay2_q = next_relay(relay2_q, rpm[SPEED_W-1:0], r2_on_q, r2_off_q,
                              mode_q[MODE_R2_EN], mode_q[MODE_R2_LATCH]);
        cur  = !mode_q[MODE_VOLTAGE];
        code = 0;
        // linear map onto the dac code, empty span, voltage mode and at or below min give zero
        if (cur && max_q > min_q && rpm > min_q) begin
            scale = longint'(CODE_MAX) / (longint'(max_q) - longint'(min_q));
            code  = (rpm - min_q) * scale;
            if (code > CODE_MAX) begin
                code = CODE_MAX;
            end
        end
        r.speed      = rpm[SPEED_W-1:0];
        r.relay1     = relay1_q;
        r.relay2     = relay2_q;
        r.code       = code[CODE_W-1:0];
        r.current_on = cur;
        return r;
    endfunction

    function automatic void apply_setting(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_TEETH:     teeth_q  = data[TEETH_W-1:0];
            REG_R1_ON:     r1_on_q  = data[SPEED_W-1:0];
            REG_R1_OFF:    r1_off_q = data[SPEED_W-1:0];
            REG_R2_ON:     r2_on_q  = data[SPEED_W-1:0];
            REG_R2_OFF:    r2_off_q = data[SPEED_W-1:0];
            REG_MIN_SPEED: min_q    = data[SPEED_W-1:0];
            REG_MAX_SPEED: max_q    = data[SPEED_W-1:0];
            REG_MODE:      mode_q   = data[MODE_W-1:0];
            default: ;
        endcase
    endfunction

    // plan holding the power-on register values
    function automatic void plan_defaults();
        foreach (plan[i]) begin
            plan[i] = '0;
        end
        plan[REG_TEETH]     = CFG_DATA_W'(TEETH_RESET);
        plan[REG_MAX_SPEED] = CFG_DATA_W'(MAX_SPEED_RESET);
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned exp_val);
        if (mismatches < PRINT_CAP) begin
            $display("[%0t] mismatch on %s: got %0d, expected %0d",
                     $realtime, what, got, exp_val);
        end
        mismatches++;
    endtask

    // one pulse count word on the input channel, with random gaps unless steady
    task automatic send_count(input logic [COUNT_W-1:0] cnt);
        @(negedge i_clk);
        if (!steady) begin
            while ($urandom_range(99) < STALL_PCT) begin
                i_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_valid       <= 1'b1;
        i_pulse_count <= cnt;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        pending_readings.push_back(predict_reading(cnt));
    endtask

    // stop sending and wait until every result has come back
    task automatic settle();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_readings.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // load all eight registers from plan, block must be idle
    task automatic write_setup();
        logic [CFG_IDX_W-1:0] idx;
        for (int i = 0; i < 8; i++) begin
            idx = CFG_IDX_W'(i);
            @(negedge i_clk);
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx;
            i_cfg_data  <= plan[idx];
            @(posedge i_clk);
            while (!o_cfg_ready) begin
                @(posedge i_clk);
            end
            apply_setting(idx, plan[idx]);
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure();
        settle();
        write_setup();
    endtask

    // power-on registers: relays disabled, current mode, teeth 1
    task automatic test_power_on_defaults();
        send_count(16'd0);
        send_count(16'd31);
        send_count(16'd500);
    endtask

    // frequency window edges and the full count range
    task automatic test_frequency_window();
        send_count(16'd30);
        send_count(16'd9999);
        send_count(16'd10000);
        send_count(16'hFFFF);
        send_count(16'd1);
    endtask

    // zero teeth gives zero speed, widest tooth count
    task automatic test_teeth_extremes();
        plan_defaults();
        plan[REG_TEETH] = 24'hFF0000;
        reconfigure();
        send_count(16'd500);
        plan[REG_TEETH] = 24'h00FFFF;
        reconfigure();
        send_count(16'd9999);
    endtask

    // auto reset relays, one with coinciding thresholds
    task automatic test_relay_auto_reset();
        plan_defaults();
        plan[REG_R1_ON]  = 24'd60000;
        plan[REG_R1_OFF] = 24'd30000;
        plan[REG_R2_ON]  = 24'd60000;
        plan[REG_R2_OFF] = 24'd60000;
        plan[REG_MODE]   = CFG_DATA_W'((1 << MODE_R1_EN) | (1 << MODE_R2_EN));
        reconfigure();
        send_count(16'd500);
        send_count(16'd400);
        send_count(16'd250);
    endtask

    // latched relays stay closed once tripped
    task automatic test_relay_latch();
        plan_defaults();
        plan[REG_R1_ON]  = 24'd60000;
        plan[REG_R1_OFF] = 24'd30000;
        plan[REG_R2_ON]  = 24'd48000;
        plan[REG_R2_OFF] = CFG_DATA_W'(SPEED_MAX);
        plan[REG_MODE]   = CFG_DATA_W'((1 << MODE_R1_EN) | (1 << MODE_R1_LATCH) |
                                       (1 << MODE_R2_EN) | (1 << MODE_R2_LATCH));
        reconfigure();
        send_count(16'd500);
        send_count(16'd31);
    endtask

    // disabled relays hold their state whatever the thresholds
    task automatic test_relay_disabled();
        plan_defaults();
        plan[REG_R1_ON]  = CFG_DATA_W'(SPEED_MAX);
        plan[REG_R1_OFF] = CFG_DATA_W'(SPEED_MAX);
        plan[REG_R2_ON]  = 24'd0;
        plan[REG_R2_OFF] = CFG_DATA_W'(SPEED_MAX);
        reconfigure();
        send_count(16'd9999);
    endtask

    // below min, inside the span, saturation and an empty span
    task automatic test_current_mapping();
        plan_defaults();
        plan[REG_MIN_SPEED] = 24'd6000;
        plan[REG_MAX_SPEED] = 24'd12000;
        reconfigure();
        send_count(16'd40);
        send_count(16'd60);
        send_count(16'd100);
        send_count(16'd200);
        plan[REG_MIN_SPEED] = CFG_DATA_W'(SPEED_MAX);
        plan[REG_MAX_SPEED] = CFG_DATA_W'(SPEED_MAX);
        reconfigure();
        send_count(16'd200);
    endtask

    // voltage mode clears the code and the current flag
    task automatic test_voltage_mode();
        plan_defaults();
        plan[REG_MODE] = 24'hFFFFE0 | CFG_DATA_W'(1 << MODE_VOLTAGE);
        reconfigure();
        send_count(16'd100);
    endtask

    function automatic logic [SPEED_W-1:0] pick_speed(input int unsigned span);
        int unsigned r;
        r = $urandom_range(99);
        if (r < 5) begin
            return '0;
        end
        if (r < 10) begin
            return SPEED_W'(SPEED_MAX);
        end
        return SPEED_W'($urandom_range(span));
    endfunction

    // random register set scaled to the speeds the tooth count can reach
    task automatic random_plan();
        int unsigned          r;
        int unsigned          span;
        logic [TEETH_W-1:0]   teeth;
        logic [SPEED_W-1:0]   lo;
        r = $urandom_range(99);
        if (r < 5) begin
            teeth = '0;
        end else if (r < 10) begin
            teeth = '1;
        end else if (r < 15) begin
            teeth = TEETH_W'($urandom);
        end else begin
            teeth = TEETH_W'($urandom_range(1, 64));
        end
        plan[REG_TEETH] = {8'($urandom), teeth};
        span = (teeth == 0) ? 1000 : TOP_RPM / teeth + 1;
        plan[REG_R1_ON]  = pick_speed(span);
        plan[REG_R1_OFF] = pick_speed(span);
        plan[REG_R2_ON]  = pick_speed(span);
        plan[REG_R2_OFF] = pick_speed(span);
        lo = pick_speed(span);
        plan[REG_MIN_SPEED] = lo;
        if ($urandom_range(99) < 10) begin
            plan[REG_MAX_SPEED] = pick_speed(span);
        end else begin
            plan[REG_MAX_SPEED] = lo + SPEED_W'($urandom_range(1, span));
        end
        plan[REG_MODE] = CFG_DATA_W'($urandom);
    endtask

    function automatic logic [COUNT_W-1:0] random_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return COUNT_W'($urandom_range(31, 9999));
        end
        if (r < 80) begin
            return COUNT_W'($urandom_range(25, 36));
        end
        if (r < 90) begin
            return COUNT_W'($urandom_range(9994, 10005));
        end
        return COUNT_W'($urandom);
    endfunction

    // random register sets, each followed by a run of counts
    task automatic test_random_traffic();
        for (int p = 0; p < PHASES; p++) begin
            random_plan();
            reconfigure();
            // a stretch with no idling on either side
            steady = (p == 6 || p == 7);
            for (int n = 0; n < WORDS_PER_PHASE; n++) begin
                send_count(random_count());
            end
        end
        steady = 1'b0;
    endtask

    // result sink with random stalls
    always @(negedge i_clk) begin
        i_ready <= steady || ($urandom_range(99) >= STALL_PCT);
    end

    // compare each result word with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_readings.size() == 0) begin
                report_mismatch("unexpected word, speed", 32'(o_speed), 0);
            end else begin
                want = pending_readings.pop_front();
                if (o_speed !== want.speed) begin
                    report_mismatch("speed", 32'(o_speed), 32'(want.speed));
                end
                if (o_relay1_closed !== want.relay1) begin
                    report_mismatch("relay1_closed", 32'(o_relay1_closed),
                                    32'(want.relay1));
                end
                if (o_relay2_closed !== want.relay2) begin
                    report_mismatch("relay2_closed", 32'(o_relay2_closed),
                                    32'(want.relay2));
                end
                if (o_current_code !== want.code) begin
                    report_mismatch("current_code", 32'(o_current_code), 32'(want.code));
                end
                if (o_current_valid !== want.current_on) begin
                    report_mismatch("current_valid", 32'(o_current_valid),
                                    32'(want.current_on));
                end
            end
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    // test sequence
    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_pulse_count = '0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = '0;
        i_cfg_data    = '0;
        i_ready       = 1'b0;
        steady        = 1'b0;
        mismatches    = 0;
        idle_cycles   = 0;
        plan_defaults();
        foreach (plan[i]) begin
            apply_setting(CFG_IDX_W'(i), plan[i]);
        end
        relay1_q = 1'b0;
        relay2_q = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_power_on_defaults();
        test_frequency_window();
        test_teeth_extremes();
        test_relay_auto_reset();
        test_relay_latch();
        test_relay_disabled();
        test_current_mapping();
        test_voltage_mode();
        test_random_traffic();

        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

/* speed_to_current_with_relay_trips.f */
rtl/core/stc_pkg.sv
rtl/core/stc_div.sv
rtl/core/stc_relay.sv
rtl/core/speed_to_current_with_relay_trips.sv
dv/speed_to_current_with_relay_trips_tb.sv
